### hw/rtl/svwm_pkg.sv
`timescale 1ns / 1ps

package svwm_pkg;

  localparam int NumVoices   = 6;
  localparam int NumSquare   = 3;
  localparam int PhaseW      = 16;
  localparam int LevelW      = 16;
  localparam int FreqW       = 17;
  localparam int ChanW       = 3;
  localparam int SampleW     = 16;
  localparam int NoiseRegs   = 4;
  localparam int NoiseRegW   = 64;
  localparam int NoiseBits   = NoiseRegs * NoiseRegW;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;
  localparam int MixShift    = 11;
  localparam int FullLevelLog = 15;   // full level is 2^15 - 1

  // signed level sum of six voices: +/-6 * 32768 fits in 19 bits
  localparam int SumW  = 19;
  // sum scaled by the full level, wide enough for bits up to MixShift+SampleW
  localparam int ProdW = SumW + FullLevelLog;

  localparam logic [SampleW-1:0] FullLevel = SampleW'((1 << FullLevelLog) - 1);

  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [ProdW-1:0] prod_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_SET    = 1'b1
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PLAY_ENABLE = 3'd0,
    CFG_NOISE_0     = 3'd1,
    CFG_NOISE_1     = 3'd2,
    CFG_NOISE_2     = 3'd3,
    CFG_NOISE_3     = 3'd4
  } cfg_idx_t;

  // command from the input handshake to the voice bank
  typedef struct packed {
    logic                     set;      // write level and step of one voice
    logic                     advance;  // step every phase after a sample
    logic [ChanW-1:0]         channel;
    logic [PhaseW-1:0]        step;
    logic signed [LevelW-1:0] level;
  } voice_cmd_t;

endpackage

### hw/rtl/six_voice_wavetable_mixer.sv
`timescale 1ns / 1ps

// Six-voice tone mixer: three square voices and three noise voices.
//
// Input channel (in_valid/in_ready): one item per transfer. operation
// OP_SET loads level and phase step (freq >> 1) of voice 'channel';
// channels 6 and 7 are dropped. OP_SAMPLE mixes all six voices and then
// steps every phase; with play_enable low it is consumed with no result.
// Output channel (out_valid/out_ready): one result per enabled sample,
// mixed_sample is bits 26..11 of the 32767-scaled sum, offset_sample is
// that value plus 32767, both wrapping mod 2^16.
// Throughput: one item per cycle while in_ready is high; the voice state
// is read and updated at the accepting edge, so back-to-back samples see
// each other's phases. Two registered stages (level sum, then output)
// form a pipeline that keeps moving while the output register drains;
// when the receiver stalls both stages fill and in_ready drops, nothing
// is lost. The user must write configuration (cfg_we, cfg_index,
// cfg_data) only when idle; the block does not enforce it. Reset clears
// the phases, steps, levels, noise pattern, play_enable and both stage
// valid flags; in_ready stays low while rst is high.
module six_voice_wavetable_mixer (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [svwm_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [svwm_pkg::CfgDataW-1:0]        cfg_data,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 operation,
  input  logic [svwm_pkg::ChanW-1:0]           channel,
  input  logic [svwm_pkg::FreqW-1:0]           freq,
  input  logic signed [svwm_pkg::LevelW-1:0]   volume,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [svwm_pkg::SampleW-1:0]  mixed_sample,
  output logic [svwm_pkg::SampleW-1:0]         offset_sample
);

  // configuration registers
  logic                                 play_enable;
  logic [svwm_pkg::NoiseBits-1:0]       noise;

  always_ff @(posedge clk) begin
    if (rst) begin
      play_enable <= 1'b0;
      noise       <= '0;
    end else if (cfg_we) begin
      unique case (svwm_pkg::cfg_idx_t'(cfg_index))
        svwm_pkg::CFG_PLAY_ENABLE: play_enable <= cfg_data[0];
        svwm_pkg::CFG_NOISE_0: noise[0*svwm_pkg::NoiseRegW +: svwm_pkg::NoiseRegW] <= cfg_data;
        svwm_pkg::CFG_NOISE_1: noise[1*svwm_pkg::NoiseRegW +: svwm_pkg::NoiseRegW] <= cfg_data;
        svwm_pkg::CFG_NOISE_2: noise[2*svwm_pkg::NoiseRegW +: svwm_pkg::NoiseRegW] <= cfg_data;
        svwm_pkg::CFG_NOISE_3: noise[3*svwm_pkg::NoiseRegW +: svwm_pkg::NoiseRegW] <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // input transfer decode
  logic                  in_fire;
  logic                  sample_fire;
  svwm_pkg::voice_cmd_t  cmd;
  svwm_pkg::sum_t        level_sum;

  assign in_fire     = in_valid && in_ready;
  assign sample_fire = in_fire && (svwm_pkg::op_t'(operation) == svwm_pkg::OP_SAMPLE)
                       && play_enable;

  always_comb begin
    cmd.set     = in_fire && (svwm_pkg::op_t'(operation) == svwm_pkg::OP_SET)
                  && (channel < svwm_pkg::ChanW'(svwm_pkg::NumVoices));
    cmd.advance = sample_fire;
    cmd.channel = channel;
    cmd.step    = freq[svwm_pkg::FreqW-1:1];
    cmd.level   = volume;
  end

  svwm_voice_bank u_voice_bank (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .noise     (noise),
    .level_sum (level_sum)
  );

  // stage 1: signed level sum of the sample in flight
  logic            s1_valid;
  svwm_pkg::sum_t  s1_sum;
  logic            out_open;
  logic            s1_open;

  assign out_open = !out_valid || out_ready;
  assign s1_open  = !s1_valid || out_open;
  assign in_ready = s1_open && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_open) begin
      s1_valid <= sample_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      s1_sum <= level_sum;
    end
  end

  // stage 2: scale by 32767 as (x << 15) - x, take bits 26..11
  svwm_pkg::prod_t                 scaled;
  logic [svwm_pkg::SampleW-1:0]    mixed_next;

  always_comb begin
    scaled = svwm_pkg::prod_t'(svwm_pkg::prod_t'(s1_sum) <<< svwm_pkg::FullLevelLog)
             - svwm_pkg::prod_t'(s1_sum);
    mixed_next = scaled[svwm_pkg::MixShift +: svwm_pkg::SampleW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s1_valid) begin
      mixed_sample  <= $signed(mixed_next);
      offset_sample <= svwm_pkg::SampleW'(mixed_next + svwm_pkg::FullLevel);
    end
  end

endmodule

### hw/rtl/svwm_voice_bank.sv
`timescale 1ns / 1ps

// Six voice registers and the signed level sum of the current wave points.
module svwm_voice_bank (
  input  logic                                clk,
  input  logic                                rst,
  input  svwm_pkg::voice_cmd_t                cmd,
  input  logic [svwm_pkg::NoiseBits-1:0]      noise,
  output svwm_pkg::sum_t                      level_sum
);

  logic [svwm_pkg::PhaseW-1:0]        phase      [svwm_pkg::NumVoices];
  logic [svwm_pkg::PhaseW-1:0]        phase_step [svwm_pkg::NumVoices];
  logic signed [svwm_pkg::LevelW-1:0] voice_level[svwm_pkg::NumVoices];

  logic [7:0]      wave_idx [svwm_pkg::NumVoices];
  logic            wave_pos [svwm_pkg::NumVoices];
  svwm_pkg::sum_t  term     [svwm_pkg::NumVoices];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < svwm_pkg::NumVoices; v++) begin
        phase[v]       <= '0;
        phase_step[v]  <= '0;
        voice_level[v] <= '0;
      end
    end else begin
      for (int v = 0; v < svwm_pkg::NumVoices; v++) begin
        if (cmd.set && (cmd.channel == svwm_pkg::ChanW'(v))) begin
          phase_step[v]  <= cmd.step;
          voice_level[v] <= cmd.level;
        end
        if (cmd.advance) begin
          phase[v] <= svwm_pkg::PhaseW'(phase[v] + phase_step[v]);
        end
      end
    end
  end

  // square voices: high for the first half of a 64-step cycle
  always_comb begin
    level_sum = '0;
    for (int v = 0; v < svwm_pkg::NumVoices; v++) begin
      wave_idx[v] = phase[v][15:8];
      if (v < svwm_pkg::NumSquare) begin
        wave_pos[v] = ~wave_idx[v][5];
      end else begin
        wave_pos[v] = noise[wave_idx[v]];
      end
      term[v] = wave_pos[v] ? svwm_pkg::sum_t'(voice_level[v])
                            : -svwm_pkg::sum_t'(voice_level[v]);
      level_sum = svwm_pkg::sum_t'(level_sum + term[v]);
    end
  end

endmodule

### dv/tb_six_voice_wavetable_mixer.sv
`timescale 1ns / 1ps

// Self-checking bench for the six-voice tone mixer.
// A sender task drives one item per transfer, a receiver process drains and
// checks results, and a voice-bank predictor in this module tracks phases,
// steps, levels, noise pattern and the play enable.
module tb_six_voice_wavetable_mixer;
  import svwm_pkg::*;

  // one expected mixer result
  typedef struct packed {
    logic signed [SampleW-1:0] mixed;
    logic [SampleW-1:0]        offset;
  } mix_out_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index = '0;
  logic [CfgDataW-1:0]        cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic                       operation = 1'b0;
  logic [ChanW-1:0]           channel   = '0;
  logic [FreqW-1:0]           freq      = '0;
  logic signed [LevelW-1:0]   volume    = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SampleW-1:0]  mixed_sample;
  logic [SampleW-1:0]         offset_sample;

  six_voice_wavetable_mixer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .channel       (channel),
    .freq          (freq),
    .volume        (volume),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mixed_sample  (mixed_sample),
    .offset_sample (offset_sample)
  );

  // ------------------------------------------------------ voice bank model
  logic [PhaseW-1:0]        tone_phase [NumVoices];
  logic [PhaseW-1:0]        tone_step  [NumVoices];
  logic signed [LevelW-1:0] tone_level [NumVoices];
  logic                     play_on;
  logic [NoiseRegW-1:0]     noise_word [NoiseRegs];

  mix_out_t sample_q [$];   // mixer results still owed by the DUT

  // knobs for idle insertion, flipped per test
  bit send_gaps   = 1'b0;
  bit recv_stalls = 1'b0;

  int errors    = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_muted   = 0;
  int n_dropped = 0;
  int stall_left = 0;

  // clock: 10 ns period
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case a transfer never completes
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void flag(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Apply one accepted item to the voice bank; a sample with play enabled
  // owes one result. Mix is sum(level * +/-full) >>> 11, low 16 bits.
  function automatic void mix_voices(op_t op, logic [ChanW-1:0] ch,
                                     logic [FreqW-1:0] f,
                                     logic signed [LevelW-1:0] vol);
    longint   acc;
    longint   full;
    logic [7:0] idx;
    logic     hi;
    mix_out_t res;
    full = longint'(FullLevel);
    if (op == OP_SET) begin
      // set keeps the phase; voices 6 and 7 do not exist
      if (ch < NumVoices) begin
        tone_level[ch] = vol;
        tone_step[ch]  = f[FreqW-1:1];
      end else begin
        n_dropped++;
      end
      return;
    end
    if (!play_on) begin
      // muted sample: no result, phases frozen
      n_muted++;
      return;
    end
    acc = 0;
    for (int v = 0; v < NumVoices; v++) begin
      idx = tone_phase[v][PhaseW-1:8];
      // square voices look at the 64-step index only
      hi  = (v < NumSquare) ? !idx[5] : noise_word[idx[7:6]][idx[5:0]];
      acc += longint'(tone_level[v]) * (hi ? full : -full);
    end
    res.mixed  = SampleW'(acc >>> MixShift);
    res.offset = res.mixed + FullLevel;
    sample_q.push_back(res);
    for (int v = 0; v < NumVoices; v++) tone_phase[v] = tone_phase[v] + tone_step[v];
  endfunction

  function automatic void check_result(logic signed [SampleW-1:0] got_mix,
                                       logic [SampleW-1:0] got_off);
    mix_out_t want;
    if (sample_q.size() == 0) begin
      flag($sformatf("unexpected result mixed=%0d offset=%0d", got_mix, got_off));
      return;
    end
    want = sample_q.pop_front();
    if (got_mix !== want.mixed)
      flag($sformatf("mixed_sample exp %0d got %0d", want.mixed, got_mix));
    if (got_off !== want.offset)
      flag($sformatf("offset_sample exp %0d got %0d", want.offset, got_off));
  endfunction

  // Receiver: check each transfer, then hold ready low for a drawn number
  // of cycles. The countdown runs whether or not a result is pending.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(mixed_sample, offset_sample);
        n_results++;
        stall_left = recv_stalls ? $urandom_range(0, 9) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Sender: optional gap, then hold valid until the transfer. Valid stays
  // high into the next item when that one draws no gap.
  task automatic send_item(op_t op, logic [ChanW-1:0] ch, logic [FreqW-1:0] f,
                           logic signed [LevelW-1:0] vol);
    int gap;
    gap = send_gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    channel   <= ch;
    freq      <= f;
    volume    <= vol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mix_voices(op, ch, f, vol);
    n_items++;
  endtask

  task automatic send_random();
    op_t                      op;
    logic [FreqW-1:0]         f;
    logic signed [LevelW-1:0] vol;
    op = ($urandom_range(0, 9) < 7) ? OP_SAMPLE : OP_SET;
    // small steps keep square edges busy, full range wraps quickly
    f = ($urandom_range(0, 3) == 0) ? FreqW'($urandom_range(0, 1023)) : FreqW'($urandom);
    case ($urandom_range(0, 7))
      0:       vol = 16'sh8000;
      1:       vol = 16'sh7fff;
      default: vol = LevelW'($urandom);
    endcase
    send_item(op, ChanW'($urandom_range(0, 7)), f, vol);
  endtask

  // Wait for every owed result, then let the pipeline settle so that a
  // set or muted sample in flight is done before registers move.
  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sample_q.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (sample_q.size() != 0) begin
      flag($sformatf("%0d results never arrived", sample_q.size()));
      sample_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // cfg_we is left high; reconfigure lowers it after the last write
  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_PLAY_ENABLE: play_on = val[0];
      CFG_NOISE_0:     noise_word[0] = val;
      CFG_NOISE_1:     noise_word[1] = val;
      CFG_NOISE_2:     noise_word[2] = val;
      CFG_NOISE_3:     noise_word[3] = val;
      default: ;
    endcase
  endtask

  task automatic reconfigure(logic en, logic [NoiseRegs-1:0][NoiseRegW-1:0] pat);
    drain();
    write_reg(CFG_PLAY_ENABLE, CfgDataW'(en));
    write_reg(CFG_NOISE_0, pat[0]);
    write_reg(CFG_NOISE_1, pat[1]);
    write_reg(CFG_NOISE_2, pat[2]);
    write_reg(CFG_NOISE_3, pat[3]);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [NoiseRegs-1:0][NoiseRegW-1:0] rand_pattern();
    logic [NoiseRegs-1:0][NoiseRegW-1:0] p;
    for (int k = 0; k < NoiseRegs; k++) p[k] = {$urandom, $urandom};
    return p;
  endfunction

  // ------------------------------------------------------------ test tasks

  // Out of reset playback is off: samples are swallowed and must not move
  // the phases, while set items still land.
  task automatic test_muted_after_reset();
    send_item(OP_SAMPLE, 3'd0, 17'd0, 16'sd0);
    send_item(OP_SET, 3'd0, 17'h00200, 16'sh7fff);
    send_item(OP_SET, 3'd3, 17'h1fffe, -16'sd20000);
    send_item(OP_SAMPLE, 3'd0, 17'd0, 16'sd0);
    send_item(OP_SAMPLE, 3'd5, 17'h1ffff, 16'sh8000);
  endtask

  // Field extremes, all channels including the absent ones, and a full
  // level mix that wraps the 16-bit sample.
  task automatic test_extremes();
    reconfigure(1'b1, {64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                       64'h0, {NoiseRegW{1'b1}}});
    send_item(OP_SAMPLE, 3'd0, 17'd0, 16'sd0);   // voice 0 still at phase 0
    send_item(OP_SET, 3'd0, 17'h1ffff, 16'sh8000);
    send_item(OP_SET, 3'd1, 17'h00000, 16'sh7fff);
    send_item(OP_SET, 3'd2, 17'h00001, -16'sd1);
    send_item(OP_SET, 3'd3, 17'h00002, 16'sh8000);
    send_item(OP_SET, 3'd4, 17'h10000, 16'sh7fff);
    send_item(OP_SET, 3'd5, 17'h00200, 16'sd1);
    send_item(OP_SET, 3'd6, 17'h1ffff, 16'sh7fff);
    send_item(OP_SET, 3'd7, 17'h1ffff, 16'sh8000);
    repeat (4) send_item(OP_SAMPLE, 3'd7, 17'h1ffff, 16'sh7fff);
    // every voice at the most negative level: sum wraps in 16 bits
    for (int v = 0; v < NumVoices; v++)
      send_item(OP_SET, ChanW'(v), 17'h04000, 16'sh8000);
    repeat (3) send_item(OP_SAMPLE, 3'd0, 17'd0, 16'sd0);
  endtask

  task automatic test_random_stream(int count, bit gaps, bit stalls);
    send_gaps   = gaps;
    recv_stalls = stalls;
    reconfigure(1'b1, rand_pattern());
    repeat (count) send_random();
  endtask

  // Playback switched off and on between blocks, with the all-ones and
  // all-zeros noise patterns among the settings.
  task automatic test_play_toggle(int per_block);
    logic [NoiseRegs-1:0][NoiseRegW-1:0] pat;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        1:       pat = '1;
        3:       pat = '0;
        default: pat = rand_pattern();
      endcase
      reconfigure(blk[0], pat);
      repeat (per_block) send_random();
    end
  endtask

  // ------------------------------------------------------------------ main
  initial begin
    for (int v = 0; v < NumVoices; v++) begin
      tone_phase[v] = '0;
      tone_step[v]  = '0;
      tone_level[v] = '0;
    end
    for (int k = 0; k < NoiseRegs; k++) noise_word[k] = '0;
    play_on = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_muted_after_reset();
    test_extremes();
    test_random_stream(230, 1'b0, 1'b0);
    test_random_stream(230, 1'b1, 1'b1);
    test_random_stream(230, 1'b1, 1'b0);
    test_random_stream(230, 1'b0, 1'b1);
    test_play_toggle(50);
    drain();

    $display("Sent %0d items: %0d mixes checked, %0d muted samples, %0d sets to absent voices",
             n_items, n_results, n_muted, n_dropped);
    $display("Covered field extremes, play on/off, extreme and random noise patterns");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/svwm_pkg.sv
hw/rtl/svwm_voice_bank.sv
hw/rtl/six_voice_wavetable_mixer.sv
dv/tb_six_voice_wavetable_mixer.sv
